// ===== rtl/tros_pkg.sv =====
// Shared types and constants of the tagged record offset scanner.
`default_nettype none

package tros_pkg;

    // Scan phase, one-hot
    typedef enum logic [2:0] {
        PH_TAG  = 3'b001,
        PH_TEXT = 3'b010,
        PH_SKIP = 3'b100
    } phase_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_FOUND    = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_BADTAG   = 2'd2
    } status_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_SCAN_MODE    = 3'd0,
        CFG_TARGET_INDEX = 3'd1,
        CFG_TEXT_CODE    = 3'd2,
        CFG_BOOL_CODE    = 3'd3,
        CFG_DATE_CODE    = 3'd4,
        CFG_TIME_CODE    = 3'd5,
        CFG_UINT_CODE    = 3'd6,
        CFG_SINT_CODE    = 3'd7
    } cfg_index_t;

    localparam int unsigned POS_W    = 17;
    localparam int unsigned TARGET_W = 16;

    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
    localparam logic [7:0] TEXT_END     = 8'h00;
    localparam logic [3:0] WIDE_LEN     = 4'd8;
    localparam logic [3:0] BOOL_LEN     = 4'd1;

endpackage

`default_nettype wire

// ===== rtl/tagged_record_offset_scanner.sv =====
// Tagged record offset scanner: streams a record buffer and reports one row or field offset.
//
// The block takes one buffer byte per cycle on the slave stream (tuser marks the first byte of a
// buffer, tlast the final byte) and gives at most one answer beat per buffer on the master
// stream: found with the byte offset of the target row start (row mode) or the offset just past
// the target field's tag (field mode), not found, or unknown tag. Every byte is decoded by a
// single compare-and-count step against the scan state, so a byte is accepted in every cycle
// while no answer beat is stalled, and an answer leaves in the cycle after the byte causing it.
// While an answer beat waits on a stalled master side the slave side is held; it opens again in
// the cycle the answer is taken. Bytes after the answer are dropped until the next first byte.
// Configuration registers are to be written while the stream is idle; the block never checks.
`default_nettype none

module tagged_record_offset_scanner #(
    parameter int unsigned BUF_BYTES = 65536
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    // Input bytes
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tuser,   // [0] first_byte
    input  wire logic        s_axis_tlast,   // last_byte
    // Answers
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata    // [1:0] status, [18:2] position, [23:19] zero
);

    import tros_pkg::*;

    localparam int unsigned CNT_W   = (BUF_BYTES > 2) ? $clog2(BUF_BYTES) : 1;
    localparam int unsigned SUM_W   = CNT_W + 1;
    localparam int unsigned EXT_W   = (SUM_W > POS_W) ? SUM_W : POS_W;
    localparam logic [CNT_W-1:0] LAST_OFF = CNT_W'(BUF_BYTES - 1);

    // Configuration registers
    logic                scan_mode_reg;
    logic [TARGET_W-1:0] target_index_reg;
    logic [7:0]          text_code_reg;
    logic [7:0]          bool_code_reg;
    logic [7:0]          date_code_reg;
    logic [7:0]          time_code_reg;
    logic [7:0]          uint_code_reg;
    logic [7:0]          sint_code_reg;

    // Scan state
    phase_t              phase_reg, phase_next;
    logic [CNT_W-1:0]    bytes_seen_reg, bytes_seen_next;
    logic [3:0]          skip_left_reg, skip_left_next;
    logic [TARGET_W-1:0] unit_count_reg, unit_count_next;
    logic                answered_reg, answered_next;

    // Output register
    logic                m_valid_reg;
    status_t             status_reg;
    logic [POS_W-1:0]    position_reg;

    // Per-beat decode
    logic                s_accept;
    phase_t              phase_cur;
    logic [CNT_W-1:0]    bytes_cur;
    logic [3:0]          skip_cur;
    logic [TARGET_W-1:0] unit_cur;
    logic                answered_cur;
    logic                at_limit;
    logic                is_last;
    logic                is_wide;
    logic [SUM_W-1:0]    off_plus1;
    logic [EXT_W-1:0]    off_ext;
    logic [POS_W-1:0]    found_pos;
    logic                give;
    status_t             give_status;
    logic [POS_W-1:0]    give_pos;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {5'd0, position_reg, status_reg};

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_mode_reg    <= 1'b0;
            target_index_reg <= '0;
            text_code_reg    <= 8'd1;
            bool_code_reg    <= 8'd2;
            date_code_reg    <= 8'd3;
            time_code_reg    <= 8'd4;
            uint_code_reg    <= 8'd5;
            sint_code_reg    <= 8'd6;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_SCAN_MODE:    scan_mode_reg    <= cfg_data[0];
                CFG_TARGET_INDEX: target_index_reg <= cfg_data;
                CFG_TEXT_CODE:    text_code_reg    <= cfg_data[7:0];
                CFG_BOOL_CODE:    bool_code_reg    <= cfg_data[7:0];
                CFG_DATE_CODE:    date_code_reg    <= cfg_data[7:0];
                CFG_TIME_CODE:    time_code_reg    <= cfg_data[7:0];
                CFG_UINT_CODE:    uint_code_reg    <= cfg_data[7:0];
                CFG_SINT_CODE:    sint_code_reg    <= cfg_data[7:0];
                default:          scan_mode_reg    <= scan_mode_reg;
            endcase
        end
    end

    // Restart the scan on a first byte
    assign phase_cur    = s_axis_tuser ? PH_TAG : phase_reg;
    assign bytes_cur    = s_axis_tuser ? '0 : bytes_seen_reg;
    assign skip_cur     = s_axis_tuser ? 4'd0 : skip_left_reg;
    assign unit_cur     = s_axis_tuser ? '0 : unit_count_reg;
    assign answered_cur = s_axis_tuser ? 1'b0 : answered_reg;

    assign at_limit  = (bytes_cur >= LAST_OFF);
    assign is_last   = s_axis_tlast || at_limit;
    assign is_wide   = (s_axis_tdata == date_code_reg) || (s_axis_tdata == time_code_reg) ||
                       (s_axis_tdata == uint_code_reg) || (s_axis_tdata == sint_code_reg);
    assign off_plus1 = {1'b0, bytes_cur} + SUM_W'(1);
    assign off_ext   = EXT_W'(off_plus1);
    assign found_pos = off_ext[POS_W-1:0];

    // Decode one byte against the scan state
    always_comb
    begin
        phase_next      = phase_cur;
        bytes_seen_next = bytes_cur;
        skip_left_next  = skip_cur;
        unit_count_next = unit_cur;
        answered_next   = answered_cur;
        give            = 1'b0;
        give_status     = ST_NOTFOUND;
        give_pos        = '0;

        if (!answered_cur)
        begin
            if (!at_limit)
            begin
                bytes_seen_next = off_plus1[CNT_W-1:0];
            end

            if (target_index_reg == '0)
            begin
                give        = 1'b1;
                give_status = ST_FOUND;
                give_pos    = POS_W'(scan_mode_reg);
            end
            else
            begin
                case (phase_cur)
                    PH_TEXT:
                    begin
                        if (s_axis_tdata == TEXT_END)
                        begin
                            phase_next = PH_TAG;
                        end
                    end
                    PH_SKIP:
                    begin
                        skip_left_next = skip_cur - 4'd1;
                        if (skip_cur == 4'd1)
                        begin
                            phase_next = PH_TAG;
                        end
                    end
                    default:
                    begin
                        if (s_axis_tdata == NEWLINE_BYTE)
                        begin
                            if (scan_mode_reg)
                            begin
                                give        = 1'b1;
                                give_status = ST_NOTFOUND;
                            end
                            else
                            begin
                                unit_count_next = unit_cur + TARGET_W'(1);
                                if (unit_count_next == target_index_reg)
                                begin
                                    give        = 1'b1;
                                    give_status = ST_FOUND;
                                    give_pos    = found_pos;
                                end
                            end
                        end
                        else if (scan_mode_reg && unit_cur == target_index_reg)
                        begin
                            give        = 1'b1;
                            give_status = ST_FOUND;
                            give_pos    = found_pos;
                        end
                        else if (s_axis_tdata == text_code_reg)
                        begin
                            phase_next = PH_TEXT;
                            if (scan_mode_reg)
                            begin
                                unit_count_next = unit_cur + TARGET_W'(1);
                            end
                        end
                        else if (is_wide || s_axis_tdata == bool_code_reg)
                        begin
                            phase_next     = PH_SKIP;
                            skip_left_next = is_wide ? WIDE_LEN : BOOL_LEN;
                            if (scan_mode_reg)
                            begin
                                unit_count_next = unit_cur + TARGET_W'(1);
                            end
                        end
                        else
                        begin
                            give        = 1'b1;
                            give_status = ST_BADTAG;
                        end
                    end
                endcase

                // End of buffer with no answer yet
                if (!give && is_last)
                begin
                    give        = 1'b1;
                    give_status = ST_NOTFOUND;
                end
            end

            if (give)
            begin
                answered_next = 1'b1;
            end
        end
    end

    // Advance the scan state on each accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_TAG;
            bytes_seen_reg <= '0;
            skip_left_reg  <= 4'd0;
            unit_count_reg <= '0;
            answered_reg   <= 1'b0;
        end
        else if (s_accept)
        begin
            phase_reg      <= phase_next;
            bytes_seen_reg <= bytes_seen_next;
            skip_left_reg  <= skip_left_next;
            unit_count_reg <= unit_count_next;
            answered_reg   <= answered_next;
        end
    end

    // Hold the answer beat until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (s_accept && give)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept && give)
        begin
            status_reg   <= give_status;
            position_reg <= give_pos;
        end
    end

    // Checks
    a_pos_zero_unless_found: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg && status_reg != ST_FOUND |-> position_reg == '0)
        else $error("position not zero on a non-found answer");

    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> status_reg == ST_FOUND || status_reg == ST_NOTFOUND ||
                        status_reg == ST_BADTAG)
        else $error("illegal status code");

    a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_SKIP |-> skip_left_reg != 4'd0)
        else $error("skip phase with nothing left to skip");

    a_answer_marks: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept && give |=> answered_reg)
        else $error("answer given without marking the buffer answered");

    a_one_answer: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept && answered_reg && !s_axis_tuser |-> !give)
        else $error("second answer for one buffer");

endmodule

`default_nettype wire
